// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== hdl/sacache_pkg.sv =====
// types and constants of the set-associative write-back cache
`timescale 1ns / 1ps

package sacache_pkg;

   localparam int ADDR_W       = 20;
   localparam int DATA_W       = 32;
   localparam int DEF_WAYS     = 4;
   localparam int DEF_SETS     = 128;
   localparam int DEF_LINE_WDS = 64;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              hit;
      logic              evicted_dirty;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_WB,
      ST_FILL,
      ST_RESP
   } st_type;

endpackage

// ===== hdl/set_assoc_cache_lru_writeback_core.sv =====
// top level: set-associative lru write-back cache with its backing memory
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Word-addressed set-associative cache (WAYS ways, SETS sets, LINE_WORDS-word lines,
// true lru, write-back, write-allocate) in front of a 2**20-word backing memory.
// After reset the block runs a clearing pass over all 2**20 backing words (one backing word a cycle,
// tag/state rows cleared alongside) and holds req_stall high until it ends.
// One transaction at a time: a hit goes from acceptance through tag lookup in the state
// memory to the result register. A miss adds the line fill out of the backing memory,
// and a dirty victim adds the write-back ahead of the fill; both walks move one word a
// cycle through the single read and write ports of the line and backing memories.
// A new transaction is taken while the previous result still waits in the output register.
module set_assoc_cache_lru_writeback_core
   import sacache_pkg::*;
#(
   parameter int WAYS       = DEF_WAYS,
   parameter int SETS       = DEF_SETS,
   parameter int LINE_WORDS = DEF_LINE_WDS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int OFF_W   = $clog2(LINE_WORDS);
   localparam int SET_W   = $clog2(SETS);
   localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
   localparam int WAY_W   = $clog2(WAYS);
   localparam int RANK_W  = WAY_W;
   localparam int CNT_W   = OFF_W + 1;
   localparam int LINE_W  = $clog2(SETS * WAYS);
   localparam int DADDR_W = LINE_W + OFF_W;
   localparam int ENTRY_W = 2 + RANK_W + TAG_W;
   localparam int V_BIT   = ENTRY_W - 1;
   localparam int D_BIT   = ENTRY_W - 2;

   typedef logic [WAYS-1:0][ENTRY_W-1:0] row_type;

   // memories
   row_type           meta_mem [SETS];
   logic [DATA_W-1:0] line_mem [SETS * WAYS * LINE_WORDS];
   logic [DATA_W-1:0] back_mem [2**ADDR_W];

   st_type state_ff, state_in;
   req_type req_ff, req_in;
   row_type meta_rd_ff;
   logic [DATA_W-1:0] dm_rd_ff, bm_rd_ff;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WAY_W-1:0]  way_ff, way_in;
   logic              hit_ff, hit_in, evd_ff, evd_in;
   logic [TAG_W-1:0]  vtag_ff, vtag_in;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [OFF_W-1:0] r_off;
   logic [SET_W-1:0] r_set;
   logic [TAG_W-1:0] r_tag;
   logic             r_wr;

   logic [WAYS-1:0]   v, d, hit_vec;
   logic [RANK_W-1:0] rk [WAYS];
   logic [TAG_W-1:0]  tg [WAYS];
   logic              any_hit, any_inv, was_valid, vict_dirty;
   logic [WAY_W-1:0]  hit_way, inv_way, lru_way, way;
   logic [RANK_W-1:0] old_rank;
   row_type           new_row;

   logic [LINE_W-1:0]  lidx;
   logic [CNT_W-1:0]   cnt_m1;
   logic               cnt_end, rsp_free, clr_done;

   logic               meta_we;
   logic [SET_W-1:0]   meta_waddr;
   row_type            meta_wdata;
   logic               dm_we;
   logic [DADDR_W-1:0] dm_waddr, dm_raddr;
   logic [DATA_W-1:0]  dm_wdata;
   logic               bm_we;
   logic [ADDR_W-1:0]  bm_waddr, bm_raddr;
   logic [DATA_W-1:0]  bm_wdata;

   assign r_off   = req_ff.address[OFF_W-1:0];
   assign r_set   = req_ff.address[OFF_W +: SET_W];
   assign r_tag   = req_ff.address[OFF_W + SET_W +: TAG_W];
   assign r_wr    = (req_ff.action == ACT_WRITE);
   assign cnt_m1  = cnt_ff - CNT_W'(1);
   assign cnt_end = (cnt_ff == CNT_W'(LINE_WORDS));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign clr_done = (clr_cnt_ff == {ADDR_W{1'b1}});

   // tag lookup, victim choice and lru update of the set row
   always_comb begin
      hit_way = '0;
      inv_way = '0;
      lru_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         v[i]  = meta_rd_ff[i][V_BIT];
         d[i]  = meta_rd_ff[i][D_BIT];
         rk[i] = meta_rd_ff[i][TAG_W +: RANK_W];
         tg[i] = meta_rd_ff[i][TAG_W-1:0];
         hit_vec[i] = v[i] && (tg[i] == r_tag);
      end
      // lowest-numbered way wins
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_way = WAY_W'(i);
         end
         if (!v[i]) begin
            inv_way = WAY_W'(i);
         end
         if (rk[i] == RANK_W'(WAYS - 1)) begin
            lru_way = WAY_W'(i);
         end
      end
      any_hit    = |hit_vec;
      any_inv    = !(&v);
      way        = any_hit ? hit_way : (any_inv ? inv_way : lru_way);
      was_valid  = any_hit || !any_inv;
      vict_dirty = !any_hit && !any_inv && d[lru_way];
      old_rank   = rk[way];
      new_row    = meta_rd_ff;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) == way) begin
            new_row[i][V_BIT]            = 1'b1;
            new_row[i][D_BIT]            = (any_hit && d[i]) || r_wr;
            new_row[i][TAG_W +: RANK_W]  = '0;
            new_row[i][TAG_W-1:0]        = r_tag;
         end else if (v[i] && (!was_valid || rk[i] < old_rank)) begin
            new_row[i][TAG_W +: RANK_W]  = rk[i] + RANK_W'(1);
         end
      end
   end

   assign lidx = LINE_W'(r_set) * LINE_W'(WAYS)
               + LINE_W'((state_ff == ST_LOOKUP) ? way : way_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP: begin
            if (any_hit) state_in = ST_RESP;
            else if (vict_dirty) state_in = ST_WB;
            else state_in = ST_FILL;
         end
         ST_WB:     if (cnt_end) state_in = ST_FILL;
         ST_FILL:   if (cnt_end) state_in = ST_RESP;
         ST_RESP:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      req_in       = req_ff;
      clr_cnt_in   = clr_cnt_ff;
      cnt_in       = '0;
      way_in       = way_ff;
      hit_in       = hit_ff;
      evd_in       = evd_ff;
      vtag_in      = vtag_ff;
      rdata_in     = rdata_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      meta_we      = 1'b0;
      meta_waddr   = r_set;
      meta_wdata   = new_row;
      dm_we        = 1'b0;
      dm_waddr     = {lidx, r_off};
      dm_wdata     = req_ff.write_data;
      dm_raddr     = {lidx, r_off};
      bm_we        = 1'b0;
      bm_waddr     = {vtag_ff, r_set, cnt_m1[OFF_W-1:0]};
      bm_wdata     = dm_rd_ff;
      bm_raddr     = {r_tag, r_set, cnt_ff[OFF_W-1:0]};
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            bm_we      = 1'b1;
            bm_waddr   = clr_cnt_ff;
            bm_wdata   = '0;
            if (clr_cnt_ff < ADDR_W'(SETS)) begin
               meta_we    = 1'b1;
               meta_waddr = clr_cnt_ff[SET_W-1:0];
               meta_wdata = '0;
            end
         end
         ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         ST_LOOKUP: begin
            meta_we = 1'b1;
            way_in  = way;
            hit_in  = any_hit;
            evd_in  = vict_dirty;
            vtag_in = tg[lru_way];
            dm_we   = any_hit && r_wr;
         end
         ST_WB: begin
            if (!cnt_end) cnt_in = cnt_ff + CNT_W'(1);
            dm_raddr = {lidx, cnt_ff[OFF_W-1:0]};
            bm_we    = (cnt_ff != '0);
         end
         ST_FILL: begin
            if (!cnt_end) cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               dm_we    = 1'b1;
               dm_waddr = {lidx, cnt_m1[OFF_W-1:0]};
               // the word being stored goes in place of the fetched one
               if (cnt_m1[OFF_W-1:0] == r_off) begin
                  rdata_in = bm_rd_ff;
                  dm_wdata = r_wr ? req_ff.write_data : bm_rd_ff;
               end else begin
                  dm_wdata = bm_rd_ff;
               end
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.hit             = hit_ff;
               rsp_in.evicted_dirty   = evd_ff;
               rsp_in.read_data       = r_wr ? '0 : (hit_ff ? dm_rd_ff : rdata_ff);
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      way_ff   <= way_in;
      hit_ff   <= hit_in;
      evd_ff   <= evd_in;
      vtag_ff  <= vtag_in;
      rdata_ff <= rdata_in;
      rsp_ff   <= rsp_in;
   end

   // state rows, read at the set of the incoming transaction
   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_rd_ff <= meta_mem[req_data.address[OFF_W +: SET_W]];
   end

   always_ff @(posedge clock) begin
      if (dm_we) line_mem[dm_waddr] <= dm_wdata;
      dm_rd_ff <= line_mem[dm_raddr];
   end

   always_ff @(posedge clock) begin
      if (bm_we) back_mem[bm_waddr] <= bm_wdata;
      bm_rd_ff <= back_mem[bm_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_CLK(a_accept_to_lookup, (req_valid && !req_stall) |=> (state_ff == ST_LOOKUP), "accepted transaction did not reach lookup")
   `ASSERT_CLK(a_single_hit_way, (state_ff == ST_LOOKUP) |-> $onehot0(hit_vec), "tag matches in more than one way")
   `ASSERT_NEVER(a_wb_on_hit, (state_ff == ST_WB) && hit_ff, "write-back started on a hit")
   `ASSERT_NEVER(a_wb_clean, (state_ff == ST_WB) && !evd_ff, "write-back of a clean victim")

endmodule

// ===== dv/cache_lru_wb_checker.sv =====
// checker: watches both channels, predicts each cache response and compares it
`timescale 1ns / 1ps

module cache_lru_wb_checker
   import sacache_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      awaiting,
   output int      hit_count,
   output int      writeback_count
);

   localparam int NWAYS  = DEF_WAYS;
   localparam int NSETS  = DEF_SETS;
   localparam int NWORDS = DEF_LINE_WDS;

   bit [DATA_W-1:0] mem_words [0:(1 << ADDR_W)-1];
   bit [DATA_W-1:0] line_data [NSETS][NWAYS][NWORDS];
   bit [6:0]        line_tag  [NSETS][NWAYS];
   bit              line_vld  [NSETS][NWAYS];
   bit              line_drt  [NSETS][NWAYS];
   int unsigned     age_rank  [NSETS][NWAYS];

   rsp_type expected_rsps [$];

   initial begin
      fail_count      = 0;
      hit_count       = 0;
      writeback_count = 0;
      foreach (line_vld[s, w]) begin
         line_vld[s][w] = 0;
         line_drt[s][w] = 0;
         age_rank[s][w] = 0;
      end
   end

   assign awaiting = expected_rsps.size();

   // make a way most recently used; older valid ways keep their order
   task automatic make_mru(input int s, input int w, input bit was_valid);
      int unsigned old_rank;
      old_rank = age_rank[s][w];
      for (int i = 0; i < NWAYS; i++)
         if (i != w && line_vld[s][i] && (!was_valid || age_rank[s][i] < old_rank))
            age_rank[s][i]++;
      age_rank[s][w] = 0;
   endtask

   task automatic cache_access(input req_type r, output rsp_type e);
      int           off, s, w;
      bit [6:0]     tg;
      bit           found;
      bit [ADDR_W-1:0] base;
      off   = r.address[5:0];
      s     = r.address[12:6];
      tg    = r.address[19:13];
      e     = '0;
      found = 0;
      w     = 0;
      for (int i = 0; i < NWAYS; i++)
         if (!found && line_vld[s][i] && line_tag[s][i] == tg) begin
            found = 1;
            w     = i;
         end
      if (found) begin
         e.hit = 1;
         make_mru(s, w, 1);
      end else begin
         for (int i = 0; i < NWAYS; i++)
            if (!found && !line_vld[s][i]) begin
               found = 1;
               w     = i;
            end
         if (found) begin
            make_mru(s, w, 0);
         end else begin
            w = 0;
            for (int i = 1; i < NWAYS; i++)
               if (age_rank[s][i] > age_rank[s][w])
                  w = i;
            // victim goes back to its own line address
            if (line_drt[s][w]) begin
               base = {line_tag[s][w], s[6:0], 6'd0};
               for (int i = 0; i < NWORDS; i++)
                  mem_words[base + i] = line_data[s][w][i];
               e.evicted_dirty = 1;
            end
            make_mru(s, w, 1);
         end
         base = {tg, s[6:0], 6'd0};
         for (int i = 0; i < NWORDS; i++)
            line_data[s][w][i] = mem_words[base + i];
         line_tag[s][w] = tg;
         line_vld[s][w] = 1;
         line_drt[s][w] = 0;
      end
      if (r.action == ACT_WRITE) begin
         line_data[s][w][off] = r.write_data;
         line_drt[s][w]       = 1;
      end else begin
         e.read_data = line_data[s][w][off];
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            cache_access(req_data, e);
            expected_rsps = {expected_rsps, e};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no transaction outstanding: %h", rsp_data);
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.read_data !== e.read_data) begin
                  $error("read_data expected %h actual %h", e.read_data, rsp_data.read_data);
                  fail_count++;
               end
               if (rsp_data.hit !== e.hit) begin
                  $error("hit expected %b actual %b", e.hit, rsp_data.hit);
                  fail_count++;
               end
               if (rsp_data.evicted_dirty !== e.evicted_dirty) begin
                  $error("evicted_dirty expected %b actual %b",
                         e.evicted_dirty, rsp_data.evicted_dirty);
                  fail_count++;
               end
               if (e.hit) hit_count++;
               if (e.evicted_dirty) writeback_count++;
            end
         end
      end
   end

endmodule

// ===== dv/tb_set_assoc_cache_lru_writeback_core.sv =====
// testbench top: clock, reset, cache traffic, verdict
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_writeback_core;
   import sacache_pkg::*;

   localparam longint CYCLE_LIMIT = 8_000_000;

   logic    clock     = 0;
   logic    reset     = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   int fail_count, awaiting, hit_count, writeback_count;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;
   bit hold_taken    = 0;
   int hold_left     = 0;
   int sent          = 0;
   longint cycles    = 0;
   bit [6:0] tag_pool [6];
   bit [6:0] set_pool [4];

   set_assoc_cache_lru_writeback_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   cache_lru_wb_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .fail_count, .awaiting, .hit_count, .writeback_count
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL set_assoc_cache_lru_writeback_core");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else if (hold_request > 0 && !hold_taken) begin
         rsp_stall  <= 1;
         hold_left  <= hold_request;
         hold_taken <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send(input logic act, input logic [ADDR_W-1:0] addr,
                       input logic [DATA_W-1:0] wdata);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid           <= 1;
      req_data.action     <= act;
      req_data.address    <= addr;
      req_data.write_data <= wdata;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (awaiting != 0) @(posedge clock);
   endtask

   task automatic random_traffic(input int count);
      logic [ADDR_W-1:0] addr;
      for (int n = 0; n < count; n++) begin
         // mostly a few busy sets with more tags than ways, so lines get evicted
         if ($urandom_range(99) < 85)
            addr = {tag_pool[$urandom_range(5)], set_pool[$urandom_range(3)],
                    6'($urandom_range(63))};
         else
            addr = ADDR_W'($urandom);
         send($urandom_range(1) ? ACT_WRITE : ACT_READ, addr, $urandom);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: extremes, hit after fill, dirty eviction and read-back
      send(ACT_READ,  20'h00000, 32'h0);
      send(ACT_WRITE, 20'h00000, 32'hFFFFFFFF);
      send(ACT_READ,  20'h00000, 32'h0);
      send(ACT_WRITE, 20'hFFFFF, 32'hA5A5A5A5);
      send(ACT_READ,  20'hFFFFF, 32'hFFFFFFFF);
      send(ACT_READ,  20'hFFFC0, 32'h0);
      for (int t = 1; t <= 5; t++)
         send(ACT_WRITE, {7'(t), 7'd5, 6'd63}, 32'h1000_0000 + t);
      send(ACT_READ, {7'd1, 7'd5, 6'd63}, 32'h0);
      send(ACT_READ, {7'd2, 7'd5, 6'd63}, 32'h0);
      send(ACT_READ, {7'd5, 7'd5, 6'd0},  32'h0);
      send(ACT_READ, {7'd3, 7'd5, 6'd63}, 32'h0);

      foreach (tag_pool[i]) tag_pool[i] = 7'($urandom);
      foreach (set_pool[i]) set_pool[i] = 7'($urandom);
      tag_pool[0] = 7'd0;
      tag_pool[1] = 7'd127;

      send_idle_pct = 26;
      recv_idle_pct = 83;
      random_traffic(450);
      drain();

      send_idle_pct = 83;
      recv_idle_pct = 26;
      random_traffic(450);

      // long receiver hold-off while the sender keeps pushing
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 400;
      random_traffic(500);

      drain();
      repeat (200) @(posedge clock);
      $display("%0d transactions sent, %0d hits, %0d dirty write-backs",
               sent, hit_count, writeback_count);
      if (fail_count == 0 && awaiting == 0)
         $display("PASS set_assoc_cache_lru_writeback_core");
      else
         $display("FAIL set_assoc_cache_lru_writeback_core");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/sacache_pkg.sv
hdl/set_assoc_cache_lru_writeback_core.sv
dv/cache_lru_wb_checker.sv
dv/tb_set_assoc_cache_lru_writeback_core.sv
